// ===== rtl/mpsd_pkg.sv =====
`timescale 1ns / 1ps
package mpsd_pkg;

  // parse phases
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_PACK    = 4'd1;
  localparam logic [3:0] PH_LEN     = 4'd2;
  localparam logic [3:0] PH_SKIP    = 4'd3;
  localparam logic [3:0] PH_PES     = 4'd4;
  localparam logic [3:0] PH_PAYLOAD = 4'd5;
  localparam logic [3:0] PH_IDLE    = 4'd6;
  localparam logic [3:0] PH_TSSTART = 4'd7;
  localparam logic [3:0] PH_PASS    = 4'd8;

  // pes header sub-phases
  localparam logic [2:0] SUB_STUFF = 3'd0;  // stuffing or marker byte
  localparam logic [2:0] SUB_MARK  = 3'd1;  // stuffing limit hit, next byte is the marker
  localparam logic [2:0] SUB_BUF   = 3'd2;  // second byte of the buffer field
  localparam logic [2:0] SUB_CODE  = 3'd3;  // code byte after the buffer field
  localparam logic [2:0] SUB_DONE  = 3'd4;  // header end known
  localparam logic [2:0] SUB_MPEG2 = 3'd5;  // mpeg-2 header, waiting for its length

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_PGM_END  = 3'd1;
  localparam logic [2:0] KIND_BAD_PACK = 3'd2;
  localparam logic [2:0] KIND_NOT_SYS  = 3'd3;
  localparam logic [2:0] KIND_BAD_ID   = 3'd4;
  localparam logic [2:0] KIND_STUFFING = 3'd5;
  localparam logic [2:0] KIND_BAD_SYNC = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_PID   = 2'd1;
  localparam logic [1:0] REG_TRACK = 2'd2;

  // stream ids with fixed handling
  localparam logic [7:0] SID_PGM_END = 8'hB9;
  localparam logic [7:0] SID_PACK    = 8'hBA;
  localparam logic [7:0] SID_PRIV1   = 8'hBD;
  localparam logic [7:0] SID_AUDIO0  = 8'hC0;

  localparam logic [7:0]  SYNC_BYTE = 8'h47;
  localparam logic [23:0] START_CODE = 24'h000001;

endpackage

// ===== rtl/mpeg_ps_ts_video_demux_unit.sv =====
`timescale 1ns / 1ps
// a result is registered in the output register, or in the skid stage while
//   the output stalls; throughput: one input beat per cycle while the skid
//   stage is empty, so input runs while a result waits in the output register
// reset: asynchronous, active low; parser returns to start code hunt, registers
//   to mode 0, pid 0, track 0xE0
module mpeg_ps_ts_video_demux_unit #(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [7:0] PktLast = 8'(TS_PACKET_BYTES);

  // configuration
  logic        mode_q;
  logic [12:0] pid_q;
  logic [7:0]  track_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      pid_q   <= '0;
      track_q <= 8'hE0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mpsd_pkg::REG_MODE:  mode_q  <= cfg_data_i[0];
        mpsd_pkg::REG_PID:   pid_q   <= cfg_data_i[12:0];
        mpsd_pkg::REG_TRACK: track_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // parser state
  logic [3:0]  phase_q, phase_d;
  logic [23:0] win_q, win_d;
  logic [8:0]  hc_q, hc_d, ht_q, ht_d;
  logic [15:0] plen_q, plen_d;
  logic [16:0] rem_q, rem_d;
  logic [2:0]  sub_q, sub_d;
  logic [7:0]  idx_q, idx_d, adapt_q, adapt_d;
  logic [3:0]  flags_q, flags_d;
  logic        await_q, await_d;

  // output skid: main and spare result registers
  logic       ovld_q, svld_q;
  logic [7:0] obyte_q, sbyte_q;
  logic [2:0] okind_q, skind_q;

  logic       acc;
  logic       res_v;
  logic [7:0] res_b;
  logic [2:0] res_k;

  assign s_axis_tready = ~svld_q;
  assign acc = s_axis_tvalid & s_axis_tready;

  logic [7:0] b;
  assign b = s_axis_tdata;

  // pes header byte helper values
  logic [8:0] hc1;
  logic [8:0] code_tgt;
  logic [3:0] bt;
  logic [16:0] pes_n;
  logic [7:0] idx1;
  logic [8:0] adapt_end;

  always_comb begin
    bt = b[7:4];
    code_tgt = hc_q + 9'd1 + ((bt == 4'd2) ? 9'd4 : (bt == 4'd3) ? 9'd9 : 9'd0);
  end

  always_comb begin
    logic [3:0] ph;
    logic       pes_go;
    logic       pes_en;
    phase_d = phase_q; win_d = win_q; hc_d = hc_q; ht_d = ht_q;
    plen_d = plen_q; rem_d = rem_q; sub_d = sub_q; idx_d = idx_q;
    adapt_d = adapt_q; flags_d = flags_q; await_d = await_q;
    res_v = 1'b0; res_b = '0; res_k = mpsd_pkg::KIND_PAYLOAD;
    hc1 = '0; pes_n = '0; idx1 = '0; adapt_end = '0; pes_go = 1'b0;
    ph = phase_q;
    if (s_axis_tuser) begin
      ph = mpsd_pkg::PH_HUNT; win_d = '1; idx_d = '0; await_d = 1'b1;
    end
    phase_d = ph;
    // in transport mode only payload bytes of a kept packet reach the pes header
    pes_en = (ph == mpsd_pkg::PH_PES) &&
             (!mode_q || (flags_q[0] && adapt_q == 8'd0 && idx_d > 8'd3 &&
                          !(idx_d == 8'd4 && flags_q[2])));
    // shared pes header byte step
    if (pes_en) begin
      if (hc_q == 9'd4) plen_d = {b, plen_q[7:0]};
      else if (hc_q == 9'd5) plen_d = {plen_q[15:8], b};
      else if (hc_q == 9'd6 && b[7:6] == 2'b10) begin
        sub_d = mpsd_pkg::SUB_MPEG2; ht_d = 9'd9;
      end else if (hc_q >= 9'd6) begin
        case (sub_q)
          mpsd_pkg::SUB_STUFF, mpsd_pkg::SUB_MARK: begin
            if (sub_q == mpsd_pkg::SUB_STUFF && b == 8'hFF) begin
              if (hc_q >= 9'd21) begin
                res_v = 1'b1; res_k = mpsd_pkg::KIND_STUFFING; sub_d = mpsd_pkg::SUB_MARK;
              end
            end else if (b[7:6] == 2'b01) sub_d = mpsd_pkg::SUB_BUF;
            else begin ht_d = code_tgt; sub_d = mpsd_pkg::SUB_DONE; end
          end
          mpsd_pkg::SUB_BUF: sub_d = mpsd_pkg::SUB_CODE;
          mpsd_pkg::SUB_CODE: begin ht_d = code_tgt; sub_d = mpsd_pkg::SUB_DONE; end
          mpsd_pkg::SUB_MPEG2: if (hc_q == 9'd8) begin
            ht_d = 9'd9 + {1'b0, b}; sub_d = mpsd_pkg::SUB_DONE;
          end
          default: ;
        endcase
      end
      hc1 = hc_q + 9'd1;
      pes_go = (sub_d == mpsd_pkg::SUB_DONE) && (hc1 >= ht_d);
      pes_n = 17'd6 + {1'b0, plen_d} - {8'd0, ht_d};
    end
    if (!mode_q) begin
      // program stream
      if (ph > mpsd_pkg::PH_PAYLOAD) begin ph = mpsd_pkg::PH_HUNT; win_d = '1; end
      phase_d = ph;
      case (ph)
        mpsd_pkg::PH_HUNT: begin
          if (win_d != mpsd_pkg::START_CODE) win_d = {win_d[15:0], b};
          else begin
            win_d = '1; hc_d = 9'd4;
            if (b == mpsd_pkg::SID_PGM_END) begin
              res_v = 1'b1; res_k = mpsd_pkg::KIND_PGM_END;
            end else if (b == mpsd_pkg::SID_PACK) begin
              phase_d = mpsd_pkg::PH_PACK; ht_d = 9'd12;
            end else if (b == mpsd_pkg::SID_PRIV1 || b == mpsd_pkg::SID_AUDIO0)
              phase_d = mpsd_pkg::PH_LEN;
            else if (b == track_q) begin
              phase_d = mpsd_pkg::PH_PES; sub_d = mpsd_pkg::SUB_STUFF;
            end else if (b < mpsd_pkg::SID_PGM_END) begin
              res_v = 1'b1; res_k = mpsd_pkg::KIND_NOT_SYS;
            end else phase_d = mpsd_pkg::PH_LEN;
          end
        end
        mpsd_pkg::PH_PACK: begin
          if (hc_q == 9'd4) begin
            if (b[7:6] == 2'b01) ht_d = 9'd14;
            else if (b[7:4] == 4'h2) ht_d = 9'd12;
            else begin
              phase_d = mpsd_pkg::PH_HUNT; win_d = '1;
              res_v = 1'b1; res_k = mpsd_pkg::KIND_BAD_PACK;
            end
          end else if (hc_q == 9'd13) ht_d = 9'd14 + {6'd0, b[2:0]};
          if (!res_v) begin
            hc_d = hc_q + 9'd1;
            if (hc_d >= ht_d) begin phase_d = mpsd_pkg::PH_HUNT; win_d = '1; end
          end
        end
        mpsd_pkg::PH_LEN: begin
          if (hc_q == 9'd4) begin plen_d = {b, 8'd0}; hc_d = 9'd5; end
          else begin
            plen_d = {plen_q[15:8], b};
            if (plen_d == 16'd0) begin phase_d = mpsd_pkg::PH_HUNT; win_d = '1; end
            else begin phase_d = mpsd_pkg::PH_SKIP; rem_d = {1'b0, plen_d}; end
          end
        end
        mpsd_pkg::PH_PES: begin
          hc_d = hc1;
          if (pes_go) begin
            if (!pes_n[16] && pes_n != 17'd0) begin
              phase_d = mpsd_pkg::PH_PAYLOAD; rem_d = pes_n;
            end else begin phase_d = mpsd_pkg::PH_HUNT; win_d = '1; end
          end
        end
        default: begin
          // skip and payload count through
          if (rem_q != 17'd0) rem_d = rem_q - 17'd1;
          if (rem_d == 17'd0) begin phase_d = mpsd_pkg::PH_HUNT; win_d = '1; end
          if (ph == mpsd_pkg::PH_PAYLOAD) begin
            res_v = 1'b1; res_b = b; res_k = mpsd_pkg::KIND_PAYLOAD;
          end
        end
      endcase
    end else begin
      // transport stream
      idx1 = idx_d + 8'd1;
      adapt_end = 9'd5 + {1'b0, b};
      if (idx_d == 8'd0 && b != mpsd_pkg::SYNC_BYTE) begin
        res_v = 1'b1; res_k = mpsd_pkg::KIND_BAD_SYNC;
        idx1 = 8'd0;
      end else if (idx_d == 8'd0) flags_d = '0;
      else if (idx_d == 8'd1)
        flags_d = {2'b00, b[6], b[4:0] == pid_q[12:8]};
      else if (idx_d == 8'd2) begin
        if (b != pid_q[7:0]) flags_d[0] = 1'b0;
      end else if (idx_d == 8'd3 || (idx_d == 8'd4 && flags_q[2])) begin
        logic do_begin, empty;
        do_begin = 1'b0; empty = 1'b0;
        if (idx_d == 8'd3) begin
          flags_d = flags_q | {b[4], b[5], 2'b00};
          adapt_d = '0;
          do_begin = ~flags_d[2];
        end else begin
          adapt_d = b;
          if (adapt_end > 9'(TS_PACKET_BYTES)) flags_d[0] = 1'b0;
          else begin do_begin = 1'b1; empty = (adapt_end == 9'(TS_PACKET_BYTES)); end
        end
        if (do_begin) begin
          if (!flags_d[0] || !flags_d[3]) flags_d[0] = 1'b0;
          else if (flags_d[1]) begin
            await_d = 1'b0;
            phase_d = empty ? mpsd_pkg::PH_IDLE : mpsd_pkg::PH_TSSTART;
            hc_d = '0;
          end else if (await_d) flags_d[0] = 1'b0;
        end
      end else if (adapt_q != 8'd0) adapt_d = adapt_q - 8'd1;
      else if (flags_q[0]) begin
        case (ph)
          mpsd_pkg::PH_TSSTART: begin
            if (hc_q < 9'd3) begin
              if (b != ((hc_q == 9'd2) ? 8'd1 : 8'd0)) phase_d = mpsd_pkg::PH_IDLE;
              else hc_d = hc_q + 9'd1;
            end else if (b[7:4] == 4'hE) begin
              phase_d = mpsd_pkg::PH_PES; sub_d = mpsd_pkg::SUB_STUFF; hc_d = 9'd4;
            end else begin
              phase_d = mpsd_pkg::PH_IDLE;
              res_v = 1'b1; res_k = mpsd_pkg::KIND_BAD_ID;
            end
          end
          mpsd_pkg::PH_PES: begin
            hc_d = hc1;
            if (pes_go) phase_d = mpsd_pkg::PH_PASS;
          end
          mpsd_pkg::PH_PASS: begin
            res_v = 1'b1; res_b = b; res_k = mpsd_pkg::KIND_PAYLOAD;
          end
          default: phase_d = mpsd_pkg::PH_IDLE;
        endcase
      end
      idx_d = (idx1 >= PktLast) ? 8'd0 : idx1;
    end
  end

  // commit parser state on accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpsd_pkg::PH_HUNT; win_q <= '1; hc_q <= '0; ht_q <= '0;
      plen_q <= '0; rem_q <= '0; sub_q <= mpsd_pkg::SUB_STUFF; idx_q <= '0;
      adapt_q <= '0; flags_q <= '0; await_q <= 1'b1;
    end else if (acc) begin
      phase_q <= phase_d; win_q <= win_d; hc_q <= hc_d; ht_q <= ht_d;
      plen_q <= plen_d; rem_q <= rem_d; sub_q <= sub_d; idx_q <= idx_d;
      adapt_q <= adapt_d; flags_q <= flags_d; await_q <= await_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0; svld_q <= 1'b0;
    end else begin
      if (!ovld_q || m_axis_tready) begin
        if (svld_q) begin
          ovld_q <= 1'b1; svld_q <= 1'b0;
        end else ovld_q <= acc & res_v;
      end else if (acc & res_v) svld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ovld_q || m_axis_tready) begin
      if (svld_q) begin obyte_q <= sbyte_q; okind_q <= skind_q; end
      else begin obyte_q <= res_b; okind_q <= res_k; end
    end else if (acc & res_v) begin
      sbyte_q <= res_b; skind_q <= res_k;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = okind_q;

`ifndef SYNTH
  // skid only fills while the output is stalled
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    svld_q |-> ovld_q) else $error("skid full with empty output");
  // packet counter stays inside the packet
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < PktLast) else $error("packet index overrun");
  // a result kind other than payload carries a zero byte
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && okind_q != mpsd_pkg::KIND_PAYLOAD) |-> obyte_q == 8'd0)
    else $error("error result with data");
`endif

endmodule

// ===== tb/mpeg_ps_ts_video_demux_unit_tb.sv =====
`timescale 1ns / 1ps
module mpeg_ps_ts_video_demux_unit_tb;

  localparam int TS_BYTES = 188;
  localparam int STALL_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  mpeg_ps_ts_video_demux_unit #(.TS_PACKET_BYTES(TS_BYTES)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected result beats, byte and kind
  typedef struct packed {
    logic [7:0] res_byte;
    logic [2:0] res_kind;
  } demux_res_t;
  demux_res_t pending_res_q[$];

  int  err_cnt = 0;
  int  res_seen = 0;
  int  bytes_sent = 0;
  bit  no_idle = 1'b0;
  bit  held_off = 1'b0;

  // shadow registers and parser state
  logic        m_ts_mode;
  logic [12:0] m_pid;
  logic [7:0]  m_track;
  logic [3:0]  m_phase;
  logic [23:0] m_window;
  logic [8:0]  m_hcnt;
  logic [8:0]  m_htgt;
  logic [7:0]  m_sid;
  logic [15:0] m_plen;
  logic [16:0] m_remain;
  logic [2:0]  m_sub;
  logic [7:0]  m_pidx;
  logic [7:0]  m_askip;
  logic [3:0]  m_pflags;
  logic        m_await;
  logic        got_res;
  demux_res_t  new_res;

  function automatic logic [7:0] rnd_byte(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic void model_init();
    m_ts_mode = 1'b0;
    m_pid = '0;
    m_track = 8'hE0;
    m_phase = mpsd_pkg::PH_HUNT;
    m_window = '1;
    m_hcnt = '0;
    m_htgt = '0;
    m_sid = '0;
    m_plen = '0;
    m_remain = '0;
    m_sub = mpsd_pkg::SUB_STUFF;
    m_pidx = '0;
    m_askip = '0;
    m_pflags = '0;
    m_await = 1'b1;
  endfunction

  function automatic void emit_res(logic [7:0] b, logic [2:0] k);
    got_res = 1'b1;
    new_res.res_byte = b;
    new_res.res_kind = k;
  endfunction

  function automatic void back_to_hunt();
    m_phase = mpsd_pkg::PH_HUNT;
    m_window = '1;
  endfunction

  // mpeg-1 code byte fixes the header end
  function automatic void pes_code_byte(logic [7:0] b, logic [8:0] hc);
    logic [8:0] extra;
    extra = (b[7:4] == 4'h2) ? 9'd4 : (b[7:4] == 4'h3) ? 9'd9 : 9'd0;
    m_htgt = hc + 9'd1 + extra;
    m_sub = mpsd_pkg::SUB_DONE;
  endfunction

  function automatic void pes_marker_byte(logic [7:0] b, logic [8:0] hc);
    if (b[7:6] == 2'b01) m_sub = mpsd_pkg::SUB_BUF;
    else pes_code_byte(b, hc);
  endfunction

  function automatic void pes_header_byte(logic [7:0] b, bit ts);
    logic [8:0] hc;
    int n;
    hc = m_hcnt;
    if (hc == 9'd4) m_plen[15:8] = b;
    else if (hc == 9'd5) m_plen[7:0] = b;
    else if (hc == 9'd6 && b[7:6] == 2'b10) begin
      m_sub = mpsd_pkg::SUB_MPEG2;
      m_htgt = 9'd9;
    end else if (hc >= 9'd6) begin
      case (m_sub)
        mpsd_pkg::SUB_STUFF: begin
          if (b == 8'hFF) begin
            if (hc >= 9'd21) begin
              emit_res(8'h00, mpsd_pkg::KIND_STUFFING);
              m_sub = mpsd_pkg::SUB_MARK;
            end
          end else pes_marker_byte(b, hc);
        end
        mpsd_pkg::SUB_MARK: pes_marker_byte(b, hc);
        mpsd_pkg::SUB_BUF: m_sub = mpsd_pkg::SUB_CODE;
        mpsd_pkg::SUB_CODE: pes_code_byte(b, hc);
        mpsd_pkg::SUB_MPEG2: begin
          if (hc == 9'd8) begin
            m_htgt = 9'd9 + {1'b0, b};
            m_sub = mpsd_pkg::SUB_DONE;
          end
        end
        default: ;
      endcase
    end
    m_hcnt = hc + 9'd1;
    if (m_sub == mpsd_pkg::SUB_DONE && m_hcnt >= m_htgt) begin
      if (ts) m_phase = mpsd_pkg::PH_PASS;
      else begin
        n = 6 + int'(m_plen) - int'(m_htgt);
        if (n > 0) begin
          m_phase = mpsd_pkg::PH_PAYLOAD;
          m_remain = n[16:0];
        end else back_to_hunt();
      end
    end
  endfunction

  function automatic void ps_byte(logic [7:0] b);
    if (m_phase > mpsd_pkg::PH_PAYLOAD) back_to_hunt();
    case (m_phase)
      mpsd_pkg::PH_HUNT: begin
        if (m_window != mpsd_pkg::START_CODE) begin
          m_window = {m_window[15:0], b};
          return;
        end
        m_window = '1;
        m_sid = b;
        m_hcnt = 9'd4;
        if (b == mpsd_pkg::SID_PGM_END) begin
          back_to_hunt();
          emit_res(8'h00, mpsd_pkg::KIND_PGM_END);
        end else if (b == mpsd_pkg::SID_PACK) begin
          m_phase = mpsd_pkg::PH_PACK;
          m_htgt = 9'd12;
        end else if (b == mpsd_pkg::SID_PRIV1 || b == mpsd_pkg::SID_AUDIO0)
          m_phase = mpsd_pkg::PH_LEN;
        else if (b == m_track) begin
          m_phase = mpsd_pkg::PH_PES;
          m_sub = mpsd_pkg::SUB_STUFF;
        end else if (b < mpsd_pkg::SID_PGM_END) begin
          back_to_hunt();
          emit_res(8'h00, mpsd_pkg::KIND_NOT_SYS);
        end else m_phase = mpsd_pkg::PH_LEN;
      end
      mpsd_pkg::PH_PACK: begin
        if (m_hcnt == 9'd4) begin
          if (b[7:6] == 2'b01) m_htgt = 9'd14;
          else if (b[7:4] == 4'h2) m_htgt = 9'd12;
          else begin
            back_to_hunt();
            emit_res(8'h00, mpsd_pkg::KIND_BAD_PACK);
            return;
          end
        end else if (m_hcnt == 9'd13) m_htgt = 9'd14 + {6'd0, b[2:0]};
        m_hcnt = m_hcnt + 9'd1;
        if (m_hcnt >= m_htgt) back_to_hunt();
      end
      mpsd_pkg::PH_LEN: begin
        if (m_hcnt == 9'd4) begin
          m_plen = {b, 8'h00};
          m_hcnt = 9'd5;
        end else begin
          m_plen[7:0] = b;
          if (m_plen == 16'd0) back_to_hunt();
          else begin
            m_phase = mpsd_pkg::PH_SKIP;
            m_remain = {1'b0, m_plen};
          end
        end
      end
      mpsd_pkg::PH_SKIP: begin
        if (m_remain > 0) m_remain = m_remain - 17'd1;
        if (m_remain == 0) back_to_hunt();
      end
      mpsd_pkg::PH_PES: pes_header_byte(b, 1'b0);
      default: begin
        if (m_remain > 0) m_remain = m_remain - 17'd1;
        if (m_remain == 0) back_to_hunt();
        emit_res(b, mpsd_pkg::KIND_PAYLOAD);
      end
    endcase
  endfunction

  function automatic void ts_payload_byte(logic [7:0] b);
    case (m_phase)
      mpsd_pkg::PH_TSSTART: begin
        if (m_hcnt < 9'd3) begin
          if (b != ((m_hcnt == 9'd2) ? 8'd1 : 8'd0)) m_phase = mpsd_pkg::PH_IDLE;
          else m_hcnt = m_hcnt + 9'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          m_sid = b;
          m_phase = mpsd_pkg::PH_PES;
          m_sub = mpsd_pkg::SUB_STUFF;
          m_hcnt = 9'd4;
        end else begin
          m_phase = mpsd_pkg::PH_IDLE;
          emit_res(8'h00, mpsd_pkg::KIND_BAD_ID);
        end
      end
      mpsd_pkg::PH_PES: pes_header_byte(b, 1'b1);
      mpsd_pkg::PH_PASS: emit_res(b, mpsd_pkg::KIND_PAYLOAD);
      default: m_phase = mpsd_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void ts_begin_payload(bit empty);
    if (!m_pflags[0] || !m_pflags[3]) begin
      m_pflags[0] = 1'b0;
      return;
    end
    if (m_pflags[1]) begin
      m_await = 1'b0;
      m_phase = empty ? mpsd_pkg::PH_IDLE : mpsd_pkg::PH_TSSTART;
      m_hcnt = '0;
    end else if (m_await) m_pflags[0] = 1'b0;
  endfunction

  function automatic void ts_byte(logic [7:0] b);
    int idx;
    idx = m_pidx;
    if (idx == 0) begin
      if (b != mpsd_pkg::SYNC_BYTE) begin
        emit_res(8'h00, mpsd_pkg::KIND_BAD_SYNC);
        return;
      end
      m_pflags = '0;
    end else if (idx == 1) begin
      m_pflags = {2'b00, b[6], b[4:0] == m_pid[12:8]};
    end else if (idx == 2) begin
      if (b != m_pid[7:0]) m_pflags[0] = 1'b0;
    end else if (idx == 3) begin
      m_pflags[2] = m_pflags[2] | b[5];
      m_pflags[3] = m_pflags[3] | b[4];
      m_askip = '0;
      if (!m_pflags[2]) ts_begin_payload(1'b0);
    end else if (idx == 4 && m_pflags[2]) begin
      m_askip = b;
      if (5 + int'(b) > TS_BYTES) m_pflags[0] = 1'b0;
      else ts_begin_payload(5 + int'(b) == TS_BYTES);
    end else if (m_askip > 0) begin
      m_askip = m_askip - 8'd1;
    end else if (m_pflags[0]) begin
      ts_payload_byte(b);
    end
    idx++;
    m_pidx = (idx >= TS_BYTES) ? 8'd0 : idx[7:0];
  endfunction

  function automatic void demux_step(logic [7:0] b, logic restart);
    got_res = 1'b0;
    if (restart) begin
      back_to_hunt();
      m_pidx = '0;
      m_await = 1'b1;
    end
    if (m_ts_mode) ts_byte(b);
    else ps_byte(b);
  endfunction

  function automatic void note_mismatch(string what, demux_res_t want, demux_res_t seen);
    if (err_cnt < 10)
      $display("%0t %s: expected byte %h kind %0d, got byte %h kind %0d", $realtime, what,
               want.res_byte, want.res_kind, seen.res_byte, seen.res_kind);
    err_cnt++;
  endfunction

  // one input beat, random idle before it
  task automatic send_byte(logic [7:0] b, logic restart);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    demux_step(b, restart);
    if (got_res) pending_res_q.push_back(new_res);
    bytes_sent++;
  endtask

  logic [7:0] seq_q[$];

  task automatic send_seq();
    foreach (seq_q[i]) send_byte(seq_q[i], $urandom_range(0, 199) == 0);
    seq_q.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      mpsd_pkg::REG_MODE:  m_ts_mode = val[0];
      mpsd_pkg::REG_PID:   m_pid = val[12:0];
      mpsd_pkg::REG_TRACK: m_track = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one random program stream unit: pes, pack, skipped packet, end code, non-system id or noise
  task automatic ps_unit();
    logic [7:0] body[$];
    int sel, n, len;
    logic [7:0] id, cb;
    len = 0;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      repeat ($urandom_range(1, 10)) seq_q.push_back(rnd_byte(0, 255));
      return;
    end
    seq_q.push_back(8'h00);
    seq_q.push_back(8'h00);
    seq_q.push_back(8'h01);
    if (sel <= 3) begin
      id = ($urandom_range(0, 4) == 0) ? 8'hE0 + rnd_byte(0, 15) : m_track;
      if ($urandom_range(0, 1)) begin
        // mpeg-2 pes header
        body.push_back(8'h80 | rnd_byte(0, 63));
        body.push_back(rnd_byte(0, 255));
        n = $urandom_range(0, 5);
        body.push_back(8'(n));
        repeat (n) body.push_back(rnd_byte(0, 255));
      end else begin
        // mpeg-1 stuffing, optional buffer field, code byte
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
        repeat (n) body.push_back(8'hFF);
        if ($urandom_range(0, 1)) begin
          body.push_back(8'h40 | rnd_byte(0, 63));
          body.push_back(rnd_byte(0, 255));
        end
        case ($urandom_range(0, 2))
          0: cb = 8'h0F;
          1: cb = 8'h20 | rnd_byte(0, 15);
          default: cb = 8'h30 | rnd_byte(0, 15);
        endcase
        body.push_back(cb);
        n = (cb[7:4] == 4'h2) ? 4 : (cb[7:4] == 4'h3) ? 9 : 0;
        repeat (n) body.push_back(rnd_byte(0, 255));
      end
      repeat ($urandom_range(0, 20)) body.push_back(rnd_byte(0, 255));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : body.size();
    end else if (sel == 4) begin
      id = mpsd_pkg::SID_PACK;
      case ($urandom_range(0, 4))
        0: body.push_back(rnd_byte(0, 255));
        1: repeat (8) body.push_back(8'h20 | rnd_byte(0, 15));
        default: begin
          body.push_back(8'h40 | rnd_byte(0, 63));
          repeat (8) body.push_back(rnd_byte(0, 255));
          cb = rnd_byte(0, 255);
          body.push_back(cb);
          repeat (cb[2:0]) body.push_back(8'hFF);
        end
      endcase
    end else if (sel == 5) begin
      case ($urandom_range(0, 2))
        0: id = mpsd_pkg::SID_PRIV1;
        1: id = mpsd_pkg::SID_AUDIO0;
        default: id = rnd_byte(8'hBB, 8'hFF);
      endcase
      len = $urandom_range(0, 12);
      repeat (len) body.push_back(rnd_byte(0, 255));
    end else if (sel == 6) id = mpsd_pkg::SID_PGM_END;
    else id = rnd_byte(0, 8'hB8);
    seq_q.push_back(id);
    if (sel <= 3 || sel == 5) begin
      seq_q.push_back(len[15:8]);
      seq_q.push_back(len[7:0]);
    end
    foreach (body[i]) seq_q.push_back(body[i]);
  endtask

  // one transport packet, mostly on the selected pid
  task automatic ts_packet();
    logic [12:0] pid;
    logic [1:0]  afc;
    logic        pusi;
    int alen, n;
    if ($urandom_range(0, 19) == 0) seq_q.push_back(rnd_byte(0, 70));
    pid = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191)) : m_pid;
    pusi = ($urandom_range(0, 99) < 40);
    afc = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd1;
    seq_q.push_back(mpsd_pkg::SYNC_BYTE);
    seq_q.push_back({1'($urandom_range(0, 1)), pusi, 1'($urandom_range(0, 1)), pid[12:8]});
    seq_q.push_back(pid[7:0]);
    seq_q.push_back({2'($urandom_range(0, 3)), afc, 4'($urandom_range(0, 15))});
    if (afc[1]) begin
      case ($urandom_range(0, 5))
        0: alen = 183;
        1: alen = $urandom_range(184, 255);
        default: alen = $urandom_range(0, 6);
      endcase
      seq_q.push_back(8'(alen));
      repeat ((alen < 184) ? alen : 0) seq_q.push_back(rnd_byte(0, 255));
    end
    if (pusi && seq_q.size() < 170) begin
      if ($urandom_range(0, 9) != 0) begin
        seq_q.push_back(8'h00);
        seq_q.push_back(8'h00);
        seq_q.push_back(8'h01);
      end
      seq_q.push_back(($urandom_range(0, 7) == 0) ? mpsd_pkg::SID_AUDIO0 :
                      8'hE0 + rnd_byte(0, 15));
      seq_q.push_back(rnd_byte(0, 255));
      seq_q.push_back(rnd_byte(0, 255));
      if ($urandom_range(0, 1)) begin
        seq_q.push_back(8'h80 | rnd_byte(0, 63));
        seq_q.push_back(rnd_byte(0, 255));
        n = $urandom_range(0, 5);
        seq_q.push_back(8'(n));
        repeat (n) seq_q.push_back(rnd_byte(0, 255));
      end else begin
        repeat ($urandom_range(0, 2)) seq_q.push_back(8'hFF);
        seq_q.push_back(8'h0F);
      end
    end
    while (seq_q.size() < TS_BYTES + 1) seq_q.push_back(rnd_byte(0, 255));
    if (seq_q[0] == mpsd_pkg::SYNC_BYTE) seq_q.pop_back();
  endtask

  // directed stimulus: byte, restart, typed flag, result flag, result byte, result kind
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       typed;
    logic       has_res;
    logic [7:0] res_byte;
    logic [2:0] res_kind;
  } dir_row_t;
  dir_row_t dir_tab[23];

  // result side: random ready, one long hold-off
  initial begin
    int hold;
    demux_res_t seen;
    demux_res_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.res_byte = m_axis_tdata;
        seen.res_kind = m_axis_tuser;
        res_seen++;
        if (pending_res_q.size() == 0) note_mismatch("unexpected beat", '0, seen);
        else begin
          want = pending_res_q.pop_front();
          if (want != seen) note_mismatch("result mismatch", want, seen);
        end
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (res_seen >= 60 && !held_off) begin
        held_off = 1'b1;
        hold = 400;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 34);
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("mpeg_ps_ts_video_demux_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    demux_res_t typed_res;
    dir_tab[0]  = '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[1]  = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[2]  = '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[3]  = '{8'hB9, 1'b0, 1'b1, 1'b1, 8'h00, mpsd_pkg::KIND_PGM_END};
    dir_tab[4]  = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[5]  = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[6]  = '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[7]  = '{8'hBA, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[8]  = '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, mpsd_pkg::KIND_BAD_PACK};
    dir_tab[9]  = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[10] = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[11] = '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[12] = '{8'h05, 1'b0, 1'b1, 1'b1, 8'h00, mpsd_pkg::KIND_NOT_SYS};
    dir_tab[13] = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[14] = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[15] = '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[16] = '{8'hE0, 1'b0, 1'b1, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[17] = '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[18] = '{8'h04, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[19] = '{8'h0F, 1'b0, 1'b0, 1'b0, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[20] = '{8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[21] = '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, mpsd_pkg::KIND_PAYLOAD};
    dir_tab[22] = '{8'hAB, 1'b0, 1'b1, 1'b1, 8'hAB, mpsd_pkg::KIND_PAYLOAD};
    model_init();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset settings
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].restart);
      if (dir_tab[i].typed) begin
        typed_res = {dir_tab[i].res_byte, dir_tab[i].res_kind};
        if (got_res != dir_tab[i].has_res || (got_res && new_res != typed_res))
          note_mismatch("directed row", typed_res, got_res ? new_res : '0);
      end
    end

    // program stream, default track, with a window of no idling
    while (bytes_sent < 450) begin
      no_idle = (bytes_sent >= 250 && bytes_sent < 400);
      ps_unit();
      send_seq();
    end
    no_idle = 1'b0;
    drain();

    // transport stream at both pid extremes
    write_reg(mpsd_pkg::REG_MODE, 16'd1);
    write_reg(mpsd_pkg::REG_PID, 16'h1FFF);
    repeat (2) begin
      ts_packet();
      send_seq();
    end
    drain();
    write_reg(mpsd_pkg::REG_PID, 16'd0);
    send_byte(8'h00, 1'b1);
    repeat (2) begin
      ts_packet();
      send_seq();
    end
    drain();

    // back to program stream on the highest track
    write_reg(mpsd_pkg::REG_MODE, 16'd0);
    write_reg(mpsd_pkg::REG_TRACK, 16'h00EF);
    send_byte(8'hFF, 1'b1);
    while (bytes_sent < 1300) begin
      ps_unit();
      send_seq();
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_res_q.size() == 0)
      $display("mpeg_ps_ts_video_demux_unit_tb: PASS");
    else
      $display("mpeg_ps_ts_video_demux_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== mpeg_ps_ts_video_demux_unit.f =====
rtl/mpsd_pkg.sv
rtl/mpeg_ps_ts_video_demux_unit.sv
tb/mpeg_ps_ts_video_demux_unit_tb.sv
